FILE: hw/rtl/affra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affra_pkg
// Shared types and codes of the aligned first-fit range allocator: word
// formats, operation codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package affra_pkg;

  // operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_REM   = 3'd1;
  localparam logic [2:0] OP_ALLOC = 3'd2;
  localparam logic [2:0] OP_CNT   = 3'd3;
  localparam logic [2:0] OP_NEXT  = 3'd4;

  // segment written into the new table
  localparam logic [2:0] EM_NONE = 3'd0;
  localparam logic [2:0] EM_SE   = 3'd1;  // operand range
  localparam logic [2:0] EM_RSRE = 3'd2;  // stored range as is
  localparam logic [2:0] EM_RSS  = 3'd3;  // stored start up to operand start
  localparam logic [2:0] EM_ERE  = 3'd4;  // operand end up to stored end

  // divider operand select
  localparam logic DIV_ALIGN = 1'b0;
  localparam logic DIV_CNT   = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [47:0] range_start;
    logic [47:0] range_end;
    logic [47:0] block_size;
    logic [47:0] alignment;
  } affra_in_t;

  typedef struct packed {
    logic [47:0] block_address;
    logic        found;
    logic [47:0] block_count;
    logic [47:0] total_free;
    logic        overflow;
  } affra_out_t;

  typedef struct packed {
    logic       load_in;
    logic       rd;
    logic [2:0] emit_sel;
    logic       merge;
    logic       set_placed;
    logic       inc_i;
    logic       div_start;
    logic       div_sel;
    logic       take_aln;
    logic       take_found;
    logic       cnt_add;
    logic       start_rem;
    logic       commit;
    logic       out_load;
  } affra_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       size_zero;
    logic       i_end;
    logic       placed;
    logic       add_lt;
    logic       add_gt;
    logic       rem_out;
    logic       rs_lt_s;
    logic       re_gt_e;
    logic       div_done;
    logic       fits;
    logic       cnt_ok;
    logic       out_free;
  } affra_sts_t;

endpackage

FILE: hw/rtl/affra_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affra_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder
// when its steps are through, flagged by a one-cycle done pulse.
// ----------------------------------------------------------------------------
module affra_div #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem,
  output logic         done
);

  localparam int KW = $clog2(W + 1);

  logic [KW-1:0] k_r;
  logic          done_r;
  logic [W-1:0]  rem_r, quo_r, dvs_r;
  logic [W:0]    sh;
  logic [W+1:0]  diff;
  logic          ge;

  // one shift-subtract step
  always_comb begin
    sh   = {rem_r, quo_r[W-1]};
    diff = {1'b0, sh} - {2'b00, dvs_r};
    ge   = ~diff[W+1];
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        k_r <= KW'(W);
      end else if (k_r != '0) begin
        k_r <= k_r - KW'(1);
        if (k_r == KW'(1)) done_r <= 1'b1;
      end
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (k_r != '0) begin
      rem_r <= ge ? diff[W-1:0] : sh[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

FILE: hw/rtl/affra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affra_dp
// Datapath: two-bank range table, operand registers, alignment and fit
// checks, shared divider, accumulators and the output register.
// ----------------------------------------------------------------------------
module affra_dp
  import affra_pkg::*;
#(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  input  affra_cmd_t cmd,
  output affra_sts_t sts,
  input  affra_in_t  in_data,
  input  logic       out_ready,
  output logic       out_valid,
  output affra_out_t out_data
);

  localparam int N  = ADDR_BITS;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = $clog2(MAX_RANGES);
  localparam int MW = $clog2(2 * MAX_RANGES);

  // table: bank 0 at the low half, bank 1 at the high half
  logic [2*N-1:0] mem_r [2*MAX_RANGES];

  logic [2:0]    op_r;
  logic [N-1:0]  s_r, e_r, size_r, align_r, at_r, addr_r, rs_r, re_r;
  logic          alloc_r, placed_r, ovf_r, found_r, ok_r, bank_r, out_valid_r;
  logic [47:0]   cnt_r;
  logic [CW-1:0] i_r, n_r, count_r;
  logic [N:0]    acc_r, total_r;
  affra_out_t    out_r;

  logic [MW-1:0] rd_addr, wr_addr;
  logic [N-1:0]  from, ws, we, pad, dvd, dvs, div_quo, div_rem, align_in;
  logic [N:0]    sum;
  logic          emit_v, div_done;

  // table addressing
  always_comb begin
    rd_addr = bank_r ? MW'(i_r[IW-1:0]) + MW'(MAX_RANGES) : MW'(i_r[IW-1:0]);
    wr_addr = bank_r ? MW'(n_r[IW-1:0]) : MW'(n_r[IW-1:0]) + MW'(MAX_RANGES);
  end

  // segment select
  always_comb begin
    ws     = s_r;
    we     = e_r;
    emit_v = 1'b1;
    unique case (cmd.emit_sel)
      EM_SE:   begin ws = s_r;  we = e_r; end
      EM_RSRE: begin ws = rs_r; we = re_r; end
      EM_RSS:  begin ws = rs_r; we = s_r; end
      EM_ERE:  begin ws = e_r;  we = re_r; end
      default: emit_v = 1'b0;
    endcase
  end

  // search start, alignment pad and divider operands
  always_comb begin
    from     = (op_r == OP_NEXT && s_r > rs_r) ? s_r : rs_r;
    pad      = align_r - div_rem;
    sum      = {1'b0, from} + {1'b0, pad};
    dvd      = (cmd.div_sel == DIV_CNT) ? re_r - at_r : from;
    dvs      = (cmd.div_sel == DIV_CNT) ? size_r : align_r;
    align_in = N'(in_data.alignment);
  end

  affra_div #(.W(N)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quo      (div_quo),
    .rem      (div_rem),
    .done     (div_done)
  );

  // table memory
  always_ff @(posedge clk) begin
    if (emit_v && n_r != CW'(MAX_RANGES)) mem_r[wr_addr] <= {ws, we};
    if (cmd.rd) {rs_r, re_r} <= mem_r[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit && !ovf_r) begin
        bank_r  <= ~bank_r;
        count_r <= n_r;
        total_r <= acc_r;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // operand and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= in_data.operation;
      s_r      <= N'(in_data.range_start);
      e_r      <= N'(in_data.range_end);
      size_r   <= N'(in_data.block_size);
      align_r  <= (align_in == '0) ? N'(1) : align_in;
      alloc_r  <= 1'b0;
      placed_r <= 1'b0;
      ovf_r    <= 1'b0;
      found_r  <= 1'b0;
      addr_r   <= '0;
      cnt_r    <= '0;
      i_r      <= '0;
      n_r      <= '0;
      acc_r    <= '0;
    end else begin
      if (emit_v) begin
        if (n_r == CW'(MAX_RANGES)) begin
          ovf_r <= 1'b1;
        end else begin
          n_r   <= n_r + CW'(1);
          acc_r <= acc_r + ({1'b0, we} - {1'b0, ws});
        end
      end
      if (cmd.merge) begin
        if (rs_r < s_r) s_r <= rs_r;
        if (re_r > e_r) e_r <= re_r;
      end
      if (cmd.set_placed) placed_r <= 1'b1;
      if (cmd.inc_i) i_r <= i_r + CW'(1);
      if (cmd.take_aln) begin
        at_r <= (div_rem == '0) ? from : sum[N-1:0];
        ok_r <= (div_rem == '0) || !sum[N];
      end
      if (cmd.take_found) begin
        addr_r  <= at_r;
        found_r <= 1'b1;
      end
      if (cmd.cnt_add) cnt_r <= cnt_r + 48'(div_quo);
      // allocate: cut the found block out of the table
      if (cmd.start_rem) begin
        op_r    <= OP_REM;
        s_r     <= at_r;
        e_r     <= at_r + size_r;
        alloc_r <= 1'b1;
        i_r     <= '0;
        n_r     <= '0;
        acc_r   <= '0;
        ovf_r   <= 1'b0;
      end
      if (cmd.commit && !ovf_r && alloc_r) begin
        addr_r  <= s_r;
        found_r <= 1'b1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.block_address <= 48'(addr_r);
      out_r.found         <= found_r;
      out_r.block_count   <= cnt_r;
      out_r.total_free    <= 48'(total_r);
      out_r.overflow      <= ovf_r;
    end
  end

  // status to the controller
  always_comb begin
    sts.op        = op_r;
    sts.empty     = s_r >= e_r;
    sts.size_zero = size_r == '0;
    sts.i_end     = i_r == count_r;
    sts.placed    = placed_r;
    sts.add_lt    = re_r < s_r;
    sts.add_gt    = rs_r > e_r;
    sts.rem_out   = re_r <= s_r || rs_r >= e_r;
    sts.rs_lt_s   = rs_r < s_r;
    sts.re_gt_e   = re_r > e_r;
    sts.div_done  = div_done;
    sts.cnt_ok    = ok_r && at_r <= re_r;
    sts.fits      = ok_r && at_r <= re_r && size_r <= re_r - at_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/affra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affra_ctrl
// Controller: walks the range table at most once per operation (twice for an
// allocate of a nonzero size that succeeds) and sequences the datapath.
// ----------------------------------------------------------------------------
module affra_ctrl
  import affra_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  affra_sts_t sts,
  output affra_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_EV     = 4'd3;
  localparam logic [3:0] S_EM2    = 4'd4;
  localparam logic [3:0] S_DV1    = 4'd5;
  localparam logic [3:0] S_FIT    = 4'd6;
  localparam logic [3:0] S_DV2    = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        priority if ((sts.op == OP_ADD || sts.op == OP_REM) && !sts.empty)
          state_nxt = S_RD;
        else if (sts.op == OP_ALLOC || sts.op == OP_NEXT)
          state_nxt = S_RD;
        else if (sts.op == OP_CNT && !sts.size_zero)
          state_nxt = S_RD;
        else
          state_nxt = S_OUT;
      end
      S_RD: begin
        if (sts.i_end) begin
          priority if (sts.op == OP_ADD) begin
            if (!sts.placed) cmd.emit_sel = EM_SE;
            state_nxt = S_COMMIT;
          end else if (sts.op == OP_REM) begin
            state_nxt = S_COMMIT;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        state_nxt = S_RD;
        priority if (sts.op == OP_ADD) begin
          priority if (sts.add_lt) begin
            cmd.emit_sel = EM_RSRE;
            cmd.inc_i    = 1'b1;
          end else if (sts.add_gt) begin
            if (!sts.placed) begin
              cmd.emit_sel   = EM_SE;
              cmd.set_placed = 1'b1;
              state_nxt      = S_EM2;
            end else begin
              cmd.emit_sel = EM_RSRE;
              cmd.inc_i    = 1'b1;
            end
          end else begin
            cmd.merge = 1'b1;
            cmd.inc_i = 1'b1;
          end
        end else if (sts.op == OP_REM) begin
          priority if (sts.rem_out) begin
            cmd.emit_sel = EM_RSRE;
            cmd.inc_i    = 1'b1;
          end else if (sts.rs_lt_s) begin
            cmd.emit_sel = EM_RSS;
            if (sts.re_gt_e) state_nxt = S_EM2;
            else cmd.inc_i = 1'b1;
          end else begin
            if (sts.re_gt_e) cmd.emit_sel = EM_ERE;
            cmd.inc_i = 1'b1;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_ALIGN;
          state_nxt     = S_DV1;
        end
      end
      S_EM2: begin
        cmd.emit_sel = (sts.op == OP_ADD) ? EM_RSRE : EM_ERE;
        cmd.inc_i    = 1'b1;
        state_nxt    = S_RD;
      end
      S_DV1: begin
        if (sts.div_done) begin
          cmd.take_aln = 1'b1;
          state_nxt    = S_FIT;
        end
      end
      S_FIT: begin
        state_nxt = S_RD;
        priority if (sts.op == OP_CNT) begin
          if (sts.cnt_ok) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_CNT;
            state_nxt     = S_DV2;
          end else begin
            cmd.inc_i = 1'b1;
          end
        end else if (sts.fits) begin
          if (sts.op == OP_ALLOC && !sts.size_zero) begin
            cmd.start_rem = 1'b1;
          end else begin
            cmd.take_found = 1'b1;
            state_nxt      = S_OUT;
          end
        end else begin
          cmd.inc_i = 1'b1;
        end
      end
      S_DV2: begin
        if (sts.div_done) begin
          cmd.cnt_add = 1'b1;
          cmd.inc_i   = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/aligned_first_fit_range_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_first_fit_range_allocator
// Keeps a sorted table of free address ranges and serves add, remove,
// allocate, count and next-free operations, one result word per input word.
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready carry one operation word, out_valid/out_ready one result
//   word. one operation is in flight at a time; in_ready is high while idle,
//   also while the previous result still waits in the output register.
// work per operation
//   add and remove: one pass over the stored ranges, none for an empty operand.
//   allocate and next free: one divider pass per range visited for the
//   alignment remainder; a successful allocate of a nonzero size adds a
//   remove pass over the table.
//   count: alignment remainder and block quotient share one bit-serial
//   divider; up to two divider passes per range.
//   the divider is restoring, one bit per cycle.
// reset
//   the table is empty after reset; no clearing pass is needed.
// stall
//   a stalled receiver holds the result; the next operation is taken and run,
//   and waits at its end until the output register is free.
// ----------------------------------------------------------------------------
module aligned_first_fit_range_allocator
  import affra_pkg::*;
#(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  affra_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output affra_out_t out_data
);

  affra_cmd_t cmd;
  affra_sts_t sts;

  // sequencer
  affra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and arithmetic
  affra_dp #(
    .MAX_RANGES (MAX_RANGES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/affra_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affra_chk
// Port-level checks of the range allocator, bound to the top level.
// ----------------------------------------------------------------------------
module affra_chk
  import affra_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input affra_out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one operation at a time
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an operation runs");

  // a found block never comes with overflow or a count
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> !out_data.overflow && out_data.block_count == '0)
    else $error("found with overflow or count");

  // an address is reported only with found
  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.block_address == '0)
    else $error("address without found");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aligned_first_fit_range_allocator affra_chk u_chk (.*);
